// ----- design/bmsrfc_pkg.sv -----
// Package for the battery-monitor reply frame checker.
// Holds the item, result and configuration types and the fixed codes.
// No dependencies; the modules and the testbench of the block import it.
package bmsrfc_pkg;

   localparam logic [7:0] START_BYTE = 8'h7E;
   localparam logic [7:0] END_BYTE = 8'h0D;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_ECHO_OK = 3'd1;
   localparam logic [2:0] ST_HDR_MISMATCH = 3'd2;
   localparam logic [2:0] ST_BAD_END = 3'd3;
   localparam logic [2:0] ST_BAD_LENGTH = 3'd4;
   localparam logic [2:0] ST_DEVICE_ERROR = 3'd5;
   localparam logic [2:0] ST_CHECK_MISMATCH = 3'd6;

   localparam logic REG_EXP_ADDRESS = 1'b0;
   localparam logic REG_EXP_COMMAND = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       frame_done;
      logic [2:0] status;
      logic [7:0] payload_length;
   } result_type;

   typedef struct packed {
      logic [7:0] expected_address;
      logic [7:0] expected_command;
   } config_type;

endpackage

// ----- design/bmsrfc_ifs.sv -----
// Channel interfaces of the reply frame checker: request, response and
// register write. Depends on nothing; the payload uses the field widths
// of the block.
interface bmsrfc_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] rx_byte;
   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface bmsrfc_rsp_if;
   logic       valid;
   logic       ready;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic       frame_done;
   logic [2:0] status;
   logic [7:0] payload_length;
   modport source (output valid, output payload_valid, output payload_byte,
                   output frame_done, output status, output payload_length,
                   input ready);
   modport sink (input valid, input payload_valid, input payload_byte,
                 input frame_done, input status, input payload_length,
                 output ready);
endinterface

interface bmsrfc_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [7:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/bms_reply_frame_checker_core.sv -----
// Top level of the battery-monitor reply frame checker.
// Depends on bmsrfc_pkg, the channel interfaces and the bmsrfc_* modules.
//
//   Channel   Direction  Carries
//   req_bus   in         kind, rx_byte (one received byte or a start item)
//   rsp_bus   out        payload_valid, payload_byte, frame_done, status,
//                        payload_length (zero or one per item)
//   csr_bus   in         index, data (expected address and command)
//
// One item per cycle is accepted unless an item with a result waits on a stalled
// result register; each item is held in the input register and its result in the
// result register, with the per-byte frame checks in between. Reset is synchronous.
// A stalled result holds its register; an item without a result still passes,
// and the input register holds one further item while the result waits.
module bms_reply_frame_checker_core #(
   parameter int MAX_LENGTH = 240
) (
   input logic          clock,
   input logic          reset,
   bmsrfc_req_if.sink   req_bus,
   bmsrfc_rsp_if.source rsp_bus,
   bmsrfc_csr_if.sink   csr_bus
);
   import bmsrfc_pkg::*;

   config_type cfg;
   item_type   item;
   result_type res;
   logic       item_valid;
   logic       res_valid;
   logic       out_busy;
   logic       advance;

   assign advance = item_valid && !(res_valid && out_busy);

   bmsrfc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   bmsrfc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   bmsrfc_parser #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .advance   (advance),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   bmsrfc_out_stage u_out_stage (
      .clock   (clock),
      .reset   (reset),
      .load    (advance && res_valid),
      .res     (res),
      .busy    (out_busy),
      .rsp_bus (rsp_bus)
   );

endmodule

// ----- design/bmsrfc_csr.sv -----
// Configuration registers of the reply frame checker.
// Depends on bmsrfc_pkg and the register write interface.
module bmsrfc_csr (
   input  logic                    clock,
   input  logic                    reset,
   bmsrfc_csr_if.sink              csr_bus,
   output bmsrfc_pkg::config_type  cfg
);
   import bmsrfc_pkg::*;

   config_type cfg_ff;
   config_type cfg_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_EXP_ADDRESS: cfg_in.expected_address = csr_bus.data;
            REG_EXP_COMMAND: cfg_in.expected_command = csr_bus.data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_address <= 8'd1;
         cfg_ff.expected_command <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/bmsrfc_in_stage.sv -----
// Input register of the reply frame checker; it also serves as skid stage.
// Depends on bmsrfc_pkg and the request interface.
module bmsrfc_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   bmsrfc_req_if.sink            req_bus,
   input  logic                  advance,
   output logic                  item_valid,
   output bmsrfc_pkg::item_type  item
);
   import bmsrfc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   logic     take;

   assign req_bus.ready = !valid_ff || advance;
   assign take = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in.kind = req_bus.kind;
         item_in.rx_byte = req_bus.rx_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

// ----- design/bmsrfc_parser.sv -----
// Frame state and per-byte checks of the reply frame checker.
// Depends on bmsrfc_pkg; the verdict for each item is computed here.
module bmsrfc_parser #(
   parameter int MAX_LENGTH = 240
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bmsrfc_pkg::item_type    item,
   input  logic                    advance,
   input  bmsrfc_pkg::config_type  cfg,
   output logic                    res_valid,
   output bmsrfc_pkg::result_type  res
);
   import bmsrfc_pkg::*;

   localparam int POS_W = $clog2(MAX_LENGTH + 2);
   localparam logic [7:0] MAX_LEN_B = 8'(MAX_LENGTH);

   localparam logic [1:0] PH_IGNORE = 2'd0;
   localparam logic [1:0] PH_HEADER = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;

   logic [1:0]       phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       len_ff, len_in;
   logic [7:0]       xor_ff, xor_in;
   logic [7:0]       sum_ff, sum_in;
   logic             hdr_ok_ff, hdr_ok_in;
   logic             chk_ok_ff, chk_ok_in;
   logic [7:0]       dev_ff, dev_in;
   logic [8:0]       pos_w;
   logic [8:0]       len_w;
   logic [7:0]       b;

   assign b = item.rx_byte;
   assign pos_w = 9'(pos_ff);
   assign len_w = {1'b0, len_ff};

   always_comb begin
      phase_in = phase_ff;
      pos_in = pos_ff;
      len_in = len_ff;
      xor_in = xor_ff;
      sum_in = sum_ff;
      hdr_ok_in = hdr_ok_ff;
      chk_ok_in = chk_ok_ff;
      dev_in = dev_ff;
      res_valid = 1'b0;
      res = '0;
      if (item.kind) begin
         phase_in = PH_HEADER;
         pos_in = '0;
         len_in = '0;
         xor_in = '0;
         sum_in = '0;
         hdr_ok_in = 1'b1;
         chk_ok_in = 1'b0;
         dev_in = '0;
      end else begin
         unique case (phase_ff)
            PH_HEADER: begin
               xor_in = xor_ff ^ b;
               sum_in = sum_ff + b;
               if (pos_w == 9'd0 && b != START_BYTE) hdr_ok_in = 1'b0;
               if (pos_w == 9'd1 && b != cfg.expected_address) hdr_ok_in = 1'b0;
               if (pos_w == 9'd2 && b != cfg.expected_command) hdr_ok_in = 1'b0;
               if (pos_w < 9'd3) begin
                  pos_in = pos_ff + POS_W'(1);
               end else begin
                  len_in = b;
                  pos_in = '0;
                  if (!hdr_ok_in) begin
                     phase_in = PH_IGNORE;
                     res_valid = 1'b1;
                     res.frame_done = 1'b1;
                     res.status = ST_HDR_MISMATCH;
                  end else if (b > MAX_LEN_B) begin
                     phase_in = PH_IGNORE;
                     res_valid = 1'b1;
                     res.frame_done = 1'b1;
                     res.status = ST_BAD_LENGTH;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               if (pos_w < len_w) begin
                  pos_in = pos_ff + POS_W'(1);
                  if (len_ff == 8'd1) begin
                     dev_in = b;
                  end else begin
                     xor_in = xor_ff ^ b;
                     sum_in = sum_ff + b;
                     res_valid = 1'b1;
                     res.payload_valid = 1'b1;
                     res.payload_byte = b;
                  end
               end else if (pos_w == len_w) begin
                  chk_ok_in = (b == (xor_ff ^ sum_ff));
                  pos_in = pos_ff + POS_W'(1);
               end else begin
                  res_valid = 1'b1;
                  res.frame_done = 1'b1;
                  phase_in = PH_IGNORE;
                  if (len_ff == 8'd0) begin
                     if (b == END_BYTE) begin
                        phase_in = PH_HEADER;
                        pos_in = '0;
                        len_in = '0;
                        xor_in = '0;
                        sum_in = '0;
                        hdr_ok_in = 1'b1;
                        chk_ok_in = 1'b0;
                        dev_in = '0;
                        res.status = ST_ECHO_OK;
                     end else begin
                        res.status = ST_BAD_END;
                     end
                  end else if (len_ff == 8'd1) begin
                     res.status = ST_DEVICE_ERROR;
                     res.payload_byte = dev_ff;
                     res.payload_length = 8'd1;
                  end else begin
                     res.payload_length = len_ff;
                     if (b != END_BYTE) begin
                        res.status = ST_BAD_END;
                     end else if (!chk_ok_ff) begin
                        res.status = ST_CHECK_MISMATCH;
                     end else begin
                        res.status = ST_OK;
                     end
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IGNORE;
         pos_ff <= '0;
         len_ff <= '0;
         xor_ff <= '0;
         sum_ff <= '0;
         hdr_ok_ff <= 1'b0;
         chk_ok_ff <= 1'b0;
         dev_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         len_ff <= len_in;
         xor_ff <= xor_in;
         sum_ff <= sum_in;
         hdr_ok_ff <= hdr_ok_in;
         chk_ok_ff <= chk_ok_in;
         dev_ff <= dev_in;
      end
   end

endmodule

// ----- design/bmsrfc_out_stage.sv -----
// Result register of the reply frame checker, driving the response channel.
// Depends on bmsrfc_pkg and the response interface.
module bmsrfc_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  bmsrfc_pkg::result_type  res,
   output logic                    busy,
   bmsrfc_rsp_if.source            rsp_bus
);
   import bmsrfc_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;
   result_type res_in;

   assign busy = valid_ff && !rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      res_in = res_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in = res;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.payload_valid = res_ff.payload_valid;
   assign rsp_bus.payload_byte = res_ff.payload_byte;
   assign rsp_bus.frame_done = res_ff.frame_done;
   assign rsp_bus.status = res_ff.status;
   assign rsp_bus.payload_length = res_ff.payload_length;

endmodule

// ----- verif/bms_reply_frame_checker_core_tb.sv -----
// Self-checking testbench for bms_reply_frame_checker_core: directed and random replies
// with random idling on both channels, checked against a scoreboard's own frame predictor.
// Depends on bmsrfc_pkg, the bmsrfc_* channel interfaces and the core itself.
`timescale 1ns / 100ps

module bms_reply_frame_checker_core_tb;
   import bmsrfc_pkg::*;

   localparam int MAX_LENGTH = 240;
   localparam int ITEM_TARGET = 650;
   localparam int WATCHDOG_LIMIT = 300;
   localparam int SETTLE_CYCLES = 6;
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_START = 1'b1;

   typedef enum logic [1:0] {SCAN_IDLE, SCAN_HEADER, SCAN_BODY} scan_phase_type;
   typedef enum int {
      FLAW_NONE, FLAW_START, FLAW_ADDR, FLAW_CMD, FLAW_LENGTH, FLAW_CHECK, FLAW_END, FLAW_CUT
   } flaw_type;

   class frame_scoreboard;
      scan_phase_type phase;
      logic [8:0] position;
      logic [7:0] length, xor_acc, sum_acc, device_code, exp_addr, exp_cmd;
      logic hdr_good, check_good;
      result_type verdict_q[$];
      int unsigned errors;

      function new();
         exp_addr = 8'd1;
         exp_cmd = 8'd1;
         phase = SCAN_IDLE;
         position = '0;
         length = '0;
         xor_acc = '0;
         sum_acc = '0;
         device_code = '0;
         hdr_good = 1'b0;
         check_good = 1'b0;
         errors = 0;
      endfunction

      function void write_reg(logic index, logic [7:0] data);
         if (index == REG_EXP_ADDRESS)
            exp_addr = data;
         else
            exp_cmd = data;
      endfunction

      function void open_frame();
         phase = SCAN_HEADER;
         position = '0;
         length = '0;
         xor_acc = '0;
         sum_acc = '0;
         device_code = '0;
         hdr_good = 1'b1;
         check_good = 1'b0;
      endfunction

      function void fold(logic [7:0] b);
         xor_acc = xor_acc ^ b;
         sum_acc = sum_acc + b;
      endfunction

      function void verdict(logic [7:0] code, logic [2:0] st, logic [7:0] plen);
         verdict_q.push_back(result_type'{1'b0, code, 1'b1, st, plen});
      endfunction

      function void note_item(item_type it);
         logic [7:0] b;
         b = it.rx_byte;
         if (it.kind == KIND_START) begin
            open_frame();
            return;
         end
         case (phase)
            SCAN_HEADER: begin
               fold(b);
               if (position == 0 && b != START_BYTE) hdr_good = 1'b0;
               if (position == 1 && b != exp_addr) hdr_good = 1'b0;
               if (position == 2 && b != exp_cmd) hdr_good = 1'b0;
               if (position < 3) begin
                  position = position + 1'b1;
               end else begin
                  length = b;
                  position = '0;
                  if (!hdr_good) begin
                     phase = SCAN_IDLE;
                     verdict(8'd0, ST_HDR_MISMATCH, 8'd0);
                  end else if (b > MAX_LENGTH) begin
                     phase = SCAN_IDLE;
                     verdict(8'd0, ST_BAD_LENGTH, 8'd0);
                  end else begin
                     phase = SCAN_BODY;
                  end
               end
            end
            SCAN_BODY: begin
               if (position < length) begin
                  position = position + 1'b1;
                  if (length == 8'd1) begin
                     device_code = b;
                  end else begin
                     fold(b);
                     verdict_q.push_back(result_type'{1'b1, b, 1'b0, ST_OK, 8'd0});
                  end
               end else if (position == length) begin
                  check_good = (b == (xor_acc ^ sum_acc));
                  position = position + 1'b1;
               end else if (length == 8'd0) begin
                  if (b == END_BYTE) begin
                     open_frame();
                     verdict(8'd0, ST_ECHO_OK, 8'd0);
                  end else begin
                     phase = SCAN_IDLE;
                     verdict(8'd0, ST_BAD_END, 8'd0);
                  end
               end else begin
                  phase = SCAN_IDLE;
                  if (length == 8'd1)
                     verdict(device_code, ST_DEVICE_ERROR, 8'd1);
                  else if (b != END_BYTE)
                     verdict(8'd0, ST_BAD_END, length);
                  else if (!check_good)
                     verdict(8'd0, ST_CHECK_MISMATCH, length);
                  else
                     verdict(8'd0, ST_OK, length);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (verdict_q.size() == 0) begin
            errors++;
            $display({"%0t: unexpected result: expected none, ",
                      "actual pv=%0b pb=%02h fd=%0b st=%0d pl=%0d"},
                     $time, got.payload_valid, got.payload_byte, got.frame_done, got.status,
                     got.payload_length);
            return;
         end
         want = verdict_q.pop_front();
         if (got.payload_valid !== want.payload_valid ||
             got.payload_byte !== want.payload_byte ||
             got.frame_done !== want.frame_done || got.status !== want.status ||
             got.payload_length !== want.payload_length) begin
            errors++;
            $display({"%0t: expected pv=%0b pb=%02h fd=%0b st=%0d pl=%0d, ",
                      "actual pv=%0b pb=%02h fd=%0b st=%0d pl=%0d"},
                     $time, want.payload_valid, want.payload_byte, want.frame_done, want.status,
                     want.payload_length, got.payload_valid, got.payload_byte, got.frame_done,
                     got.status, got.payload_length);
         end
      endfunction

      function int unsigned pending();
         return verdict_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   bmsrfc_req_if req_bus ();
   bmsrfc_rsp_if rsp_bus ();
   bmsrfc_csr_if csr_bus ();

   bms_reply_frame_checker_core #(
      .MAX_LENGTH(MAX_LENGTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   frame_scoreboard sb = new();
   int unsigned items_sent = 0;
   int unsigned req_calm = 0;
   int unsigned rsp_calm = 0;
   int unsigned idle_cycles = 0;
   logic [7:0] cur_addr = 8'd1;
   logic [7:0] cur_cmd = 8'd1;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned draw_gap(ref int unsigned calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) calm = $urandom_range(10, 40);
      return $urandom_range(0, 17);
   endfunction

   function automatic logic [7:0] pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 12) return 8'd0;
      if (r < 22) return 8'd1;
      if (r < 95) return 8'($urandom_range(2, 12));
      if (r < 98) return 8'($urandom_range(13, MAX_LENGTH));
      return 8'(MAX_LENGTH);
   endfunction

   task automatic send_item(input logic kind, input logic [7:0] rx_byte);
      int unsigned gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind <= kind;
      req_bus.rx_byte <= rx_byte;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic send_reply(input logic [7:0] len, input flaw_type flaw, input bit with_start);
      logic [7:0] frame_q[$];
      logic [7:0] xacc, sacc, pb;
      int n;
      if (flaw == FLAW_LENGTH) len = 8'($urandom_range(MAX_LENGTH + 1, 255));
      if (with_start) send_item(KIND_START, 8'($urandom));
      frame_q = {START_BYTE, cur_addr, cur_cmd, len};
      case (flaw)
         FLAW_START: frame_q[0] = frame_q[0] ^ 8'($urandom_range(1, 255));
         FLAW_ADDR: frame_q[1] = frame_q[1] ^ 8'($urandom_range(1, 255));
         FLAW_CMD: frame_q[2] = frame_q[2] ^ 8'($urandom_range(1, 255));
         default: ;
      endcase
      xacc = '0;
      sacc = '0;
      foreach (frame_q[i]) begin
         xacc = xacc ^ frame_q[i];
         sacc = sacc + frame_q[i];
      end
      for (int i = 0; i < len; i++) begin
         pb = 8'($urandom);
         frame_q.push_back(pb);
         if (len != 8'd1) begin
            xacc = xacc ^ pb;
            sacc = sacc + pb;
         end
      end
      pb = xacc ^ sacc;
      if (flaw == FLAW_CHECK) pb = pb ^ 8'($urandom_range(1, 255));
      frame_q.push_back(pb);
      pb = END_BYTE;
      if (flaw == FLAW_END) pb = pb ^ 8'($urandom_range(1, 255));
      frame_q.push_back(pb);
      n = frame_q.size();
      if (flaw inside {FLAW_START, FLAW_ADDR, FLAW_CMD} || len > MAX_LENGTH)
         n = 4 + $urandom_range(0, 2);
      else if (flaw == FLAW_CUT)
         n = $urandom_range(1, n - 1);
      for (int i = 0; i < n; i++) send_item(KIND_BYTE, frame_q[i]);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic index, input logic [7:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= data;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   task automatic set_config(input logic [7:0] addr, input logic [7:0] cmd);
      wait_idle();
      write_reg(REG_EXP_ADDRESS, addr);
      write_reg(REG_EXP_COMMAND, cmd);
      csr_bus.valid <= 1'b0;
      cur_addr = addr;
      cur_cmd = cmd;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_result(result_type'{rsp_bus.payload_valid, rsp_bus.payload_byte,
                                         rsp_bus.frame_done, rsp_bus.status,
                                         rsp_bus.payload_length});
         if (req_bus.valid && req_bus.ready)
            sb.note_item(item_type'{req_bus.kind, req_bus.rx_byte});
         if (csr_bus.valid && csr_bus.ready)
            sb.write_reg(csr_bus.index, csr_bus.data);
         if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int unsigned stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap(rsp_calm);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin
      logic [7:0] addr_plan[4];
      logic [7:0] cmd_plan[4];
      int unsigned random_start, cfg_step, r;
      logic [7:0] len;
      flaw_type flaw;
      bit chain;

      req_bus.valid <= 1'b0;
      req_bus.kind <= KIND_BYTE;
      req_bus.rx_byte <= 8'd0;
      rsp_bus.ready <= 1'b0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= REG_EXP_ADDRESS;
      csr_bus.data <= 8'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      addr_plan = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
      cmd_plan = '{8'hFF, 8'h00, 8'($urandom), 8'($urandom)};

      // Directed: ignored byte, echo with a chained over-long header, device error,
      // and an address mismatch.
      send_item(KIND_BYTE, 8'hFF);
      send_reply(8'd0, FLAW_NONE, 1'b1);
      send_reply(8'd255, FLAW_NONE, 1'b0);
      send_reply(8'd1, FLAW_NONE, 1'b1);
      send_reply(8'd2, FLAW_ADDR, 1'b1);

      random_start = items_sent;
      cfg_step = 0;
      chain = 1'b0;
      while (items_sent - random_start < ITEM_TARGET) begin
         if (cfg_step < 4 && items_sent - random_start >= (cfg_step + 1) * 130) begin
            set_config(addr_plan[cfg_step], cmd_plan[cfg_step]);
            cfg_step++;
            chain = 1'b0;
         end
         r = $urandom_range(0, 99);
         if (r < 8) begin
            repeat ($urandom_range(1, 4))
               send_item(($urandom_range(0, 4) == 0) ? KIND_START : KIND_BYTE, 8'($urandom));
            chain = 1'b0;
         end else begin
            flaw = (r < 68) ? FLAW_NONE : flaw_type'($urandom_range(FLAW_START, FLAW_CUT));
            len = pick_length();
            send_reply(len, flaw, !(chain && $urandom_range(0, 1)));
            chain = (flaw == FLAW_NONE && len == 8'd0);
         end
      end

      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES + 2) @(posedge clock);
      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
